@@ rtl/rcpl_pkg.sv @@
// Shared types and constants of the RC pulse lamp controller.
`default_nettype none

package rcpl_pkg;

   // Pulse width counters
   localparam int COUNT_WIDTH = 16;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam int THRESH_W = 16;
   localparam int CMP_W = (COUNT_WIDTH > THRESH_W) ? COUNT_WIDTH : THRESH_W;

   // Channel order
   localparam int NUM_CH = 4;
   localparam int CH_CONTROL = 0;
   localparam int CH_ONOFF = 1;
   localparam int CH_BRIGHT = 2;
   localparam int CH_COLOR = 3;

   // Reset widths and thresholds
   localparam int CONTROL_INIT = 1500;
   localparam int MODE_INIT = 1000;
   localparam int THRESH_INIT = 1500;

   // Control width scaling window
   localparam int SCALE_LO = 1000;
   localparam int SCALE_HI = 2000;
   localparam int SPAN_W = 10;

   // Reciprocal of 25 for the scaled widths (exact below 2^15)
   localparam int RECIP_25 = 5243;
   localparam int RECIP_SHIFT = 17;

   // Configuration port
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 16;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MODE_THRESHOLD = 4'd0,
      CSR_SWITCH_THRESHOLD = 4'd1
   } csr_index_type;

   // Stream payloads
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 1;
   localparam int LEVEL_W = 8;
   localparam int RSP_LAMP_BIT = 0;
   localparam int RSP_DIMMER_LSB = 1;
   localparam int RSP_RED_LSB = 9;
   localparam int RSP_GREEN_LSB = 17;
   localparam int RSP_BLUE_LSB = 25;
   localparam int RSP_USED_W = 33;

   // Per-channel measurement result for one tick
   typedef struct packed {
      logic                   fall;
      logic [COUNT_WIDTH-1:0] width;
   } meas_type;

endpackage

`default_nettype wire

@@ rtl/rcpl_pulse_meas.sv @@
// Pulse width measurement of one receiver channel.
`default_nettype none

module rcpl_pulse_meas
   import rcpl_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire logic     level,
   output meas_type      meas
);

   logic                   prev_ff, prev_in;
   logic                   armed_ff, armed_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] count_inc;
   logic                   rise, fall;

   // Count the armed pulse, then react to the edges of this tick
   always_comb begin
      count_inc = count_ff;
      if (armed_ff && (count_ff != COUNT_MAX)) begin
         count_inc = count_ff + COUNT_WIDTH'(1);
      end
      rise = level && !prev_ff;
      fall = !level && prev_ff && armed_ff;
      prev_in = level;
      armed_in = armed_ff;
      count_in = count_inc;
      if (rise) begin
         armed_in = 1'b1;
         count_in = '0;
      end else if (fall) begin
         armed_in = 1'b0;
         count_in = '0;
      end
      meas.fall = advance && fall;
      meas.width = count_inc;
   end

   // Hold the channel state between ticks
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= 1'b1;
         armed_ff <= 1'b0;
         count_ff <= '0;
      end else if (advance) begin
         prev_ff <= prev_in;
         armed_ff <= armed_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/rc_pulse_led_mode_controller.sv @@
// Top level of the RC pulse lamp controller.
`default_nettype none

// Each req transaction is one timebase tick carrying the four receiver pin
// levels; each produces exactly one rsp transaction. A tick is accepted in
// every cycle the pipeline has room, and its result passes in order through
// channel update and threshold compare, width offset and constant scaling,
// reciprocal divide by 25, and hue to color conversion into the output
// register. req_tready follows rsp_tready through the stage valid chain, so
// the block keeps taking ticks while the output register is occupied as
// long as an earlier stage is empty. The lamp outputs hold their last value
// between completed control pulses; rsp_tuser marks the ticks that refreshed
// them. csr_ready is always high; write thresholds only while no tick is in
// flight.
module rc_pulse_led_mode_controller
   import rcpl_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // req_tdata: control_level, onoff_mode_level, bright_mode_level,
   // color_mode_level, zero padding
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   // rsp_tdata: lamp_on, dimmer_level, red_level, green_level, blue_level,
   // zero padding
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   // rsp_tuser: updated
   output logic [RSP_USER_W-1:0]       rsp_tuser,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   // Configuration registers
   logic [THRESH_W-1:0] mode_thresh_ff;
   logic [THRESH_W-1:0] switch_thresh_ff;

   // Pipeline control
   logic en1, en2, en3, en_out;
   logic req_fire;

   // Channel state
   meas_type               meas [NUM_CH];
   logic [COUNT_WIDTH-1:0] latched_ff [NUM_CH];
   logic [COUNT_WIDTH-1:0] latched_in [NUM_CH];

   // Stage 1
   logic                   v1_ff, done1_ff, done1_in, lamp1_ff, lamp1_in;
   logic [2:0]             en1_ff, en1_in;
   logic [COUNT_WIDTH-1:0] w1_ff, w1_in;

   // Stage 2
   logic              v2_ff, done2_ff, lamp2_ff;
   logic [2:0]        en2_ff;
   logic [SPAN_W-1:0] span;
   logic [15:0]       bprod2_ff, bprod2_in;
   logic [13:0]       hprod2_ff, hprod2_in;

   // Stage 3
   logic         v3_ff, done3_ff, lamp3_ff;
   logic [2:0]   en3_ff;
   logic [26:0]  bquot, hquot;
   logic [7:0]   bright3_ff;
   logic [8:0]   hue3_ff;

   // Output stage
   logic [2:0]   sext;
   logic [8:0]   base;
   logic [5:0]   rem, tval;
   logic [9:0]   ramp10;
   logic [7:0]   ramp, red, green, blue;
   logic         rsp_valid_ff;
   logic [RSP_USED_W-1:0] rsp_data_ff, rsp_data_in;
   logic         rsp_user_ff;

   // Take threshold writes at any time
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_thresh_ff <= THRESH_W'(THRESH_INIT);
         switch_thresh_ff <= THRESH_W'(THRESH_INIT);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE_THRESHOLD:   mode_thresh_ff <= csr_data;
            CSR_SWITCH_THRESHOLD: switch_thresh_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Advance each stage when it is empty or its successor moves
   assign en_out = !rsp_valid_ff || rsp_tready;
   assign en3 = !v3_ff || en_out;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;
   assign req_fire = req_tvalid && en1;

   // Measure the four channels
   for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
      rcpl_pulse_meas u_meas (
         .clock   (clock),
         .reset   (reset),
         .advance (req_fire),
         .level   (req_tdata[c]),
         .meas    (meas[c])
      );
      assign latched_in[c] = meas[c].fall ? meas[c].width : latched_ff[c];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CH; c++) begin
            latched_ff[c] <= (c == CH_CONTROL) ? COUNT_WIDTH'(CONTROL_INIT)
                                               : COUNT_WIDTH'(MODE_INIT);
         end
      end else if (req_fire) begin
         latched_ff <= latched_in;
      end
   end

   // Compare mode widths and the switch threshold
   always_comb begin
      done1_in = meas[CH_CONTROL].fall;
      w1_in = latched_in[CH_CONTROL];
      lamp1_in = CMP_W'(w1_in) > CMP_W'(switch_thresh_ff);
      en1_in[0] = CMP_W'(latched_in[CH_ONOFF]) > CMP_W'(mode_thresh_ff);
      en1_in[1] = CMP_W'(latched_in[CH_BRIGHT]) > CMP_W'(mode_thresh_ff);
      en1_in[2] = CMP_W'(latched_in[CH_COLOR]) > CMP_W'(mode_thresh_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         done1_ff <= done1_in;
         w1_ff <= w1_in;
         lamp1_ff <= lamp1_in;
         en1_ff <= en1_in;
      end
   end

   // Clamp the width offset to the window and scale by 51 and 9
   always_comb begin
      if (w1_ff <= COUNT_WIDTH'(SCALE_LO)) begin
         span = '0;
      end else if (w1_ff >= COUNT_WIDTH'(SCALE_HI)) begin
         span = SPAN_W'(SCALE_HI - SCALE_LO);
      end else begin
         span = SPAN_W'(w1_ff - COUNT_WIDTH'(SCALE_LO));
      end
      bprod2_in = (16'(span) << 5) + (16'(span) << 4) + (16'(span) << 1) + 16'(span);
      hprod2_in = (14'(span) << 3) + 14'(span);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         done2_ff <= done1_ff;
         lamp2_ff <= lamp1_ff;
         en2_ff <= en1_ff;
         bprod2_ff <= bprod2_in;
         hprod2_ff <= hprod2_in;
      end
   end

   // Divide by 200 and by 25 through the reciprocal of 25
   assign bquot = 27'(bprod2_ff[15:3]) * 27'(RECIP_25);
   assign hquot = 27'(hprod2_ff) * 27'(RECIP_25);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         done3_ff <= done2_ff;
         lamp3_ff <= lamp2_ff;
         en3_ff <= en2_ff;
         bright3_ff <= bquot[RECIP_SHIFT+7:RECIP_SHIFT];
         hue3_ff <= hquot[RECIP_SHIFT+8:RECIP_SHIFT];
      end
   end

   // Split the hue into sextant and ramp
   always_comb begin
      if (hue3_ff >= 9'd300) begin
         sext = 3'd5;
         base = 9'd300;
      end else if (hue3_ff >= 9'd240) begin
         sext = 3'd4;
         base = 9'd240;
      end else if (hue3_ff >= 9'd180) begin
         sext = 3'd3;
         base = 9'd180;
      end else if (hue3_ff >= 9'd120) begin
         sext = 3'd2;
         base = 9'd120;
      end else if (hue3_ff >= 9'd60) begin
         sext = 3'd1;
         base = 9'd60;
      end else begin
         sext = 3'd0;
         base = 9'd0;
      end
      rem = 6'(hue3_ff - base);
      tval = sext[0] ? 6'(6'd60 - rem) : rem;
      // 255/60 is 17/4
      ramp10 = (10'(tval) << 4) + 10'(tval);
      ramp = ramp10[9:2];
      red = '0;
      green = '0;
      blue = '0;
      case (sext)
         3'd0: begin
            red = 8'hFF;
            green = ramp;
         end
         3'd1: begin
            red = ramp;
            green = 8'hFF;
         end
         3'd2: begin
            green = 8'hFF;
            blue = ramp;
         end
         3'd3: begin
            green = ramp;
            blue = 8'hFF;
         end
         3'd4: begin
            red = ramp;
            blue = 8'hFF;
         end
         default: begin
            red = 8'hFF;
            blue = ramp;
         end
      endcase
   end

   // Refresh the held outputs on a completed control pulse
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (done3_ff) begin
         rsp_data_in[RSP_LAMP_BIT] = en3_ff[0] && lamp3_ff;
         rsp_data_in[RSP_DIMMER_LSB +: LEVEL_W] = en3_ff[1] ? bright3_ff : '0;
         rsp_data_in[RSP_RED_LSB +: LEVEL_W] = en3_ff[2] ? red : '0;
         rsp_data_in[RSP_GREEN_LSB +: LEVEL_W] = en3_ff[2] ? green : '0;
         rsp_data_in[RSP_BLUE_LSB +: LEVEL_W] = en3_ff[2] ? blue : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_data_ff <= '0;
         rsp_user_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= v3_ff;
         if (v3_ff) begin
            rsp_data_ff <= rsp_data_in;
            rsp_user_ff <= done3_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = RSP_DATA_W'(rsp_data_ff);
   assign rsp_tuser = rsp_user_ff;

endmodule

`default_nettype wire

@@ rtl/rcpl_checker.sv @@
// Port-level checks of the RC pulse lamp controller and their binding.
`default_nettype none

module rcpl_checker
   import rcpl_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic [RSP_USER_W-1:0]  rsp_tuser
);

   logic [RSP_DATA_W-1:0] last_ff, last_in;
   logic [LEVEL_W-1:0]    red, green, blue;

   // Track the outputs of the last delivered transaction
   assign last_in = (rsp_tvalid && rsp_tready) ? rsp_tdata : last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else begin
         last_ff <= last_in;
      end
   end

   assign red = rsp_tdata[RSP_RED_LSB +: LEVEL_W];
   assign green = rsp_tdata[RSP_GREEN_LSB +: LEVEL_W];
   assign blue = rsp_tdata[RSP_BLUE_LSB +: LEVEL_W];

   // A stalled result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   // Outputs hold between completed control pulses
   a_outputs_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == last_ff)
      else $error("outputs changed without a completed pulse");

   // A lit color lamp always has one channel at full
   a_color_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (red == 8'hFF) || (green == 8'hFF) || (blue == 8'hFF)
                     || ((red == 8'h00) && (green == 8'h00) && (blue == 8'h00)))
      else $error("color lamp has no full channel");

   // Padding bits stay clear
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:RSP_USED_W] == '0)
      else $error("rsp padding bits set");

   // No result directly after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

endmodule

bind rc_pulse_led_mode_controller rcpl_checker u_rcpl_checker (.*);

`default_nettype wire
